[rtl/core/connected_region_counter_defines.svh]
// Assertion macros shared by the region counter RTL.
`ifndef CONNECTED_REGION_COUNTER_DEFINES_SVH
`define CONNECTED_REGION_COUNTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CRC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("connected_region_counter: same-cycle check failed");
`define CRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("connected_region_counter: next-cycle check failed");
`else
`define CRC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define CRC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/crc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package crc_pkg;
    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 128;
    localparam int STACK_DEPTH = 16384;

    localparam int GRID_CELLS = MAX_COLS * MAX_ROWS;
    localparam int X_W        = $clog2(MAX_COLS);
    localparam int Y_W        = $clog2(MAX_ROWS);
    localparam int DIM_W      = ((X_W > Y_W) ? X_W : Y_W) + 1;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int CNT_W      = CELL_W + 1;
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W       = STK_AW + 1;
    localparam int ENTRY_W    = X_W + Y_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 14;

    localparam logic [COUNT_W-1:0]    COUNT_MAX   = 14'd16383;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET   = 8'd128;
    localparam logic [CFG_IDX_W-1:0]  REG_GRID_COLS = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_GRID_ROWS = 8'd1;

    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_UP    = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // A size of zero counts as one, and sizes above the limit saturate.
    function automatic dim_t eff_dim(input logic [CFG_DATA_W-1:0] v, input int unsigned lim);
        logic [31:0] ext;
        begin
            ext = 32'(v);
            if (ext == 32'd0) begin
                return dim_t'(1);
            end else if (ext > 32'(lim)) begin
                return dim_t'(lim);
            end
            return dim_t'(ext);
        end
    endfunction
endpackage
`default_nettype wire

[rtl/core/connected_region_counter.sv]
// Loading accepts a cell on each transfer; s_ready is high only while loading.
// After the last cell, cells not loaded are cleared and each cell is scanned (read, check);
// a filled cell starts a flood fill whose stack pops step through POP, POP_WAIT and IDX, then
// each neighbor through NB_SEL and, inside the grid, NB_CHK (grid memory read). The count is
// registered in the DONE state once the output is free, and holds until its transfer. Reset
// (aresetn, synchronous) clears control state and sets both sizes to 128; the grid and stack memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "connected_region_counter_defines.svh"
module connected_region_counter (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [crc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [crc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_cell_occupied,
    input  wire                                s_last_cell,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [crc_pkg::COUNT_W-1:0]        m_region_count
);
    import crc_pkg::*;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_POP_WAIT = 4'd5;
    localparam logic [3:0] S_IDX      = 4'd6;
    localparam logic [3:0] S_NB_SEL   = 4'd7;
    localparam logic [3:0] S_NB_CHK   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [CFG_DATA_W-1:0] cfg_cols_reg, cfg_rows_reg;
    dim_t                  cols_reg, cols_next, rows_reg, rows_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      load_addr_reg, load_addr_next;
    logic [CNT_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [X_W-1:0]        sx_reg, sx_next;
    logic [Y_W-1:0]        sy_reg, sy_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [X_W-1:0]        cur_x_reg, cur_x_next;
    logic [Y_W-1:0]        cur_y_reg, cur_y_next;
    logic [CELL_W-1:0]     idx_reg, idx_next;
    logic [1:0]            nb_reg, nb_next;
    logic [CELL_W-1:0]     nb_addr_reg, nb_addr_next;
    entry_t                nb_entry_reg, nb_entry_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;

    dim_t             cols_now, rows_now;
    logic [CNT_W-1:0] total_now;
    logic [CNT_W-1:0] scan_addr_adv;
    logic [X_W-1:0]   sx_adv;
    logic [Y_W-1:0]   sy_adv;
    logic             nb_ok;
    logic [CELL_W-1:0] nb_addr;
    logic [X_W-1:0]   nb_x;
    logic [Y_W-1:0]   nb_y;

    logic              grid_mem [GRID_CELLS];
    logic              grid_re, grid_we, grid_wdata, grid_rdata_reg;
    logic [CELL_W-1:0] grid_raddr, grid_waddr;
    entry_t            stk_mem [STACK_DEPTH];
    logic              stk_re, stk_we;
    logic [STK_AW-1:0] stk_raddr, stk_waddr;
    entry_t            stk_wdata, stk_rdata_reg;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == S_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_region_count = m_count_reg;

    assign cols_now  = eff_dim(cfg_cols_reg, MAX_COLS);
    assign rows_now  = eff_dim(cfg_rows_reg, MAX_ROWS);
    assign total_now = CNT_W'(CNT_W'(cols_now) * CNT_W'(rows_now));

    always_comb begin
        scan_addr_adv = scan_addr_reg + CNT_W'(1);
        if ((DIM_W'(sx_reg) + DIM_W'(1)) == cols_reg) begin
            sx_adv = '0;
            sy_adv = sy_reg + Y_W'(1);
        end else begin
            sx_adv = sx_reg + X_W'(1);
            sy_adv = sy_reg;
        end
    end

    always_comb begin
        nb_x = cur_x_reg;
        nb_y = cur_y_reg;
        unique case (nb_reg)
            NB_LEFT: begin
                nb_ok   = (cur_x_reg != '0);
                nb_addr = idx_reg - CELL_W'(1);
                nb_x    = cur_x_reg - X_W'(1);
            end
            NB_UP: begin
                nb_ok   = (cur_y_reg != '0);
                nb_addr = idx_reg - CELL_W'(cols_reg);
                nb_y    = cur_y_reg - Y_W'(1);
            end
            NB_RIGHT: begin
                nb_ok   = (DIM_W'(cur_x_reg) + DIM_W'(1)) < cols_reg;
                nb_addr = idx_reg + CELL_W'(1);
                nb_x    = cur_x_reg + X_W'(1);
            end
            NB_DOWN: begin
                nb_ok   = (DIM_W'(cur_y_reg) + DIM_W'(1)) < rows_reg;
                nb_addr = idx_reg + CELL_W'(cols_reg);
                nb_y    = cur_y_reg + Y_W'(1);
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        total_next     = total_reg;
        load_addr_next = load_addr_reg;
        scan_addr_next = scan_addr_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sp_next        = sp_reg;
        count_next     = count_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        idx_next       = idx_reg;
        nb_next        = nb_reg;
        nb_addr_next   = nb_addr_reg;
        nb_entry_next  = nb_entry_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_count_next   = m_count_reg;
        grid_re        = 1'b0;
        grid_raddr     = scan_addr_reg[CELL_W-1:0];
        grid_we        = 1'b0;
        grid_waddr     = load_addr_reg[CELL_W-1:0];
        grid_wdata     = 1'b0;
        stk_re         = 1'b0;
        stk_raddr      = STK_AW'(sp_reg - SP_W'(1));
        stk_we         = 1'b0;
        stk_waddr      = sp_reg[STK_AW-1:0];
        stk_wdata      = nb_entry_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (load_addr_reg < total_now) begin
                        grid_we        = 1'b1;
                        grid_wdata     = s_cell_occupied;
                        load_addr_next = load_addr_reg + CNT_W'(1);
                    end
                    if (s_last_cell) begin
                        cols_next  = cols_now;
                        rows_next  = rows_now;
                        total_next = total_now;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (load_addr_reg < total_reg) begin
                    grid_we        = 1'b1;
                    load_addr_next = load_addr_reg + CNT_W'(1);
                end else begin
                    load_addr_next = '0;
                    scan_addr_next = '0;
                    sx_next        = '0;
                    sy_next        = '0;
                    count_next     = '0;
                    state_next     = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (scan_addr_reg < total_reg) begin
                    grid_re    = 1'b1;
                    state_next = S_SCAN_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CHK: begin
                if (grid_rdata_reg) begin
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    grid_we    = 1'b1;
                    grid_waddr = scan_addr_reg[CELL_W-1:0];
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {sy_reg, sx_reg};
                    sp_next    = SP_W'(1);
                    state_next = S_POP;
                end else begin
                    scan_addr_next = scan_addr_adv;
                    sx_next        = sx_adv;
                    sy_next        = sy_adv;
                    state_next     = S_SCAN_RD;
                end
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    scan_addr_next = scan_addr_adv;
                    sx_next        = sx_adv;
                    sy_next        = sy_adv;
                    state_next     = S_SCAN_RD;
                end else begin
                    stk_re     = 1'b1;
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                cur_x_next = stk_rdata_reg[X_W-1:0];
                cur_y_next = stk_rdata_reg[ENTRY_W-1:X_W];
                state_next = S_IDX;
            end
            S_IDX: begin
                idx_next   = CELL_W'(CELL_W'(cur_y_reg) * CELL_W'(cols_reg)
                                     + CELL_W'(cur_x_reg));
                nb_next    = NB_LEFT;
                state_next = S_NB_SEL;
            end
            S_NB_SEL: begin
                if (nb_ok) begin
                    grid_re       = 1'b1;
                    grid_raddr    = nb_addr;
                    nb_addr_next  = nb_addr;
                    nb_entry_next = {nb_y, nb_x};
                    state_next    = S_NB_CHK;
                end else if (nb_reg == NB_DOWN) begin
                    state_next = S_POP;
                end else begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            S_NB_CHK: begin
                if (grid_rdata_reg && (sp_reg < SP_W'(STACK_DEPTH))) begin
                    grid_we    = 1'b1;
                    grid_waddr = nb_addr_reg;
                    stk_we     = 1'b1;
                    sp_next    = sp_reg + SP_W'(1);
                end
                if (nb_reg == NB_DOWN) begin
                    state_next = S_POP;
                end else begin
                    nb_next    = nb_reg + 2'd1;
                    state_next = S_NB_SEL;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_reg;
                    sp_next      = '0;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_re) begin
            grid_rdata_reg <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            cfg_cols_reg  <= CFG_RESET;
            cfg_rows_reg  <= CFG_RESET;
            load_addr_reg <= '0;
            scan_addr_reg <= '0;
            sp_reg        <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            load_addr_reg <= load_addr_next;
            scan_addr_reg <= scan_addr_next;
            sp_reg        <= sp_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                if (cfg_index == REG_GRID_COLS) begin
                    cfg_cols_reg <= cfg_data;
                end else if (cfg_index == REG_GRID_ROWS) begin
                    cfg_rows_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cols_reg     <= cols_next;
        rows_reg     <= rows_next;
        total_reg    <= total_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        idx_reg      <= idx_next;
        nb_reg       <= nb_next;
        nb_addr_reg  <= nb_addr_next;
        nb_entry_reg <= nb_entry_next;
        m_count_reg  <= m_count_next;
    end

    `CRC_ASSERT_NEXT(a_done_loads_result, aclk, aresetn, (state_reg == S_DONE) && (!m_valid_reg || m_ready), m_valid_reg && (state_reg == S_LOAD))
    `CRC_ASSERT_SAME(a_scan_in_range, aclk, aresetn, state_reg == S_SCAN_RD, scan_addr_reg <= total_reg)
    `CRC_ASSERT_SAME(a_push_clears_cell, aclk, aresetn, stk_we, grid_we && !grid_wdata)
    `CRC_ASSERT_SAME(a_scan_column_valid, aclk, aresetn, state_reg == S_SCAN_CHK, DIM_W'(sx_reg) < cols_reg)
endmodule
`default_nettype wire
